// ===== src/breakpoint_envelope_generator_macros.svh =====
// Assertion macros for the breakpoint envelope generator.
`ifndef BREAKPOINT_ENVELOPE_GENERATOR_MACROS_SVH
`define BREAKPOINT_ENVELOPE_GENERATOR_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define BPE_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bpe assertion failed");

// When pre holds, post must hold in the following cycle.
`define BPE_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("bpe assertion failed");

`else

`define BPE_ASSERT(name, clk, rstn, prop)
`define BPE_ASSERT_NEXT(name, clk, rstn, pre, post)

`endif

`endif

// ===== src/bpe_pkg.sv =====
// Shared types and constants of the breakpoint envelope generator.
package bpe_pkg;

  localparam int ENV_W   = 20;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 3;
  localparam int TIME_W  = 17;
  localparam int LEVEL_W = 16;
  localparam int GAIN_W  = 16;
  localparam int SEG_W   = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam int BREAKPOINTS_DEF = 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_ENV_SAMPLES = 1'b0;
  localparam logic [ENV_W-1:0] ENV_RESET = 20'd88200;

  // gains are Q2.30, bounded to [0, 2.0]
  localparam int ACC_W = 32;
  localparam logic [ACC_W-1:0] GAIN_MAX = 32'h8000_0000;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [MUL_B_W-1:0] MIX_Q16      = 20'd3277;
  localparam logic [MUL_B_W-1:0] MIX_KEEP_Q16 = 20'd62259;
  localparam int MIX_FRAC  = 16;
  localparam int MIX_SUM_W = ACC_W + MIX_FRAC;
  localparam logic [MIX_SUM_W-1:0] MIX_HALF = 48'd32768;

  localparam int SLOPE_SHIFT = 31;
  localparam int DIV_NUM_W   = LEVEL_W + SLOPE_SHIFT;
  localparam int DIV_DEN_W   = ENV_W + TIME_W;
  localparam int SLOPE_W     = DIV_NUM_W + 1;

  localparam logic [TIME_W-1:0] TIME_END = 17'd65536;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_WRITE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  ptime;
  } point_t;

endpackage

// ===== src/breakpoint_envelope_generator.sv =====
// Top level of the breakpoint envelope generator: sequencer, shared multiplier, state, ports.
`include "breakpoint_envelope_generator_macros.svh"

// Each beat on the slave stream carries one operation in tuser: a sample tick, a note start, a
// note release or a breakpoint write. Every beat gives exactly one master beat with the gain,
// segment and release flag after the operation. A tick is worked one step at a time by a small
// sequencer: two table reads, one pass through the shared 32x20 multiplier for the slope's
// denominator, then a restoring divider that produces one quotient bit per cycle, then the
// segment and raw gain update and two more multiplier passes for the smoother. A tick's output
// beat is loaded into the result register once the sequencer reaches its output state and the
// register is free, and the sequencer then returns to idle; note start, release and breakpoint
// writes go straight from idle to the output state. The slave side is ready only while the
// sequencer is idle; the result register lets a new beat in while an earlier result still waits.
module breakpoint_envelope_generator import bpe_pkg::*; #(
  parameter int BREAKPOINTS = BREAKPOINTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: point_index[2:0], point_time[19:3], point_level[35:20], zero[39:36]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: gain[15:0], segment[18:16], releasing[19], zero[23:20]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int AW = $clog2(BREAKPOINTS);
  localparam logic [AW-1:0] SUSTAIN = AW'(BREAKPOINTS - 2);
  localparam int SUM_W = SLOPE_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_MULD,
    ST_DIVS,
    ST_DIVW,
    ST_UPD,
    ST_MRAW,
    ST_MSM,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic                   m_tvalid_q;
  logic [OUT_DATA_W-1:0]  m_tdata_q;

  logic [ENV_W-1:0]       env_q;
  logic [AW-1:0]          seg_q;
  logic                   rel_q;
  logic [ACC_W-1:0]       raw_q;
  logic [ACC_W-1:0]       smooth_q;

  point_t                 p0_q;
  point_t                 p1_q;
  logic [DIV_DEN_W-1:0]   den_q;
  logic [LEVEL_W-1:0]     mag_q;
  logic                   neg_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic [MIX_SUM_W-1:0]   acc_q;

  op_e                    in_op;
  logic [IDX_W-1:0]       in_idx;
  point_t                 in_point;
  logic                   accept;
  logic                   pt_we;
  logic [AW-1:0]          pt_raddr;
  point_t                 pt_rdata;

  logic signed [LEVEL_W:0] dl;
  logic signed [TIME_W:0]  dt;
  logic [TIME_W-1:0]       dt_mag;
  logic [LEVEL_W-1:0]      dl_mag;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [MIX_SUM_W-1:0]   mix_sum;

  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_quo;

  logic                   slope_pos;
  logic                   slope_neg;
  logic [ACC_W-1:0]       next_level;
  logic [AW-1:0]          seg_d;
  logic signed [SLOPE_W-1:0] slope_eff;
  logic signed [SUM_W-1:0]   raw_sum;
  logic [ACC_W-1:0]       raw_d;

  logic [ACC_W:0]         gain_sum;
  logic [GAIN_W-1:0]      gain;
  logic                   cfg_wr;
  logic                   out_load;

  // input beat fields
  assign in_op          = op_e'(s_axis_tuser);
  assign in_idx         = s_axis_tdata[IDX_W-1:0];
  assign in_point.ptime = s_axis_tdata[IDX_W +: TIME_W];
  assign in_point.level = s_axis_tdata[IDX_W+TIME_W +: LEVEL_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pt_we         = accept && (in_op == OP_WRITE) && (32'(in_idx) < BREAKPOINTS);
  assign pt_raddr      = (state_q == ST_RD0) ? seg_q + AW'(1) : seg_q;

  bpe_points #(
    .BREAKPOINTS(BREAKPOINTS)
  ) u_points (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pt_we),
    .waddr_i (AW'(in_idx)),
    .wdata_i (in_point),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  // segment differences
  assign dl     = $signed({1'b0, p1_q.level}) - $signed({1'b0, p0_q.level});
  assign dt     = $signed({1'b0, p1_q.ptime}) - $signed({1'b0, p0_q.ptime});
  assign dt_mag = TIME_W'(dt[TIME_W] ? -dt : dt);
  assign dl_mag = LEVEL_W'(dl[LEVEL_W] ? -dl : dl);

  // shared multiplier
  always_comb begin
    case (state_q)
      ST_MULD: begin
        mul_a = MUL_A_W'(dt_mag);
        mul_b = env_q;
      end
      ST_MRAW: begin
        mul_a = raw_q;
        mul_b = MIX_Q16;
      end
      ST_MSM: begin
        mul_a = smooth_q;
        mul_b = MIX_KEEP_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mix_sum = MIX_SUM_W'(mul_p) + acc_q;

  bpe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIVS),
    .num_i   (mag_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // segment advance and raw gain
  assign slope_pos  = !slope_q[SLOPE_W-1] && (slope_q != '0);
  assign slope_neg  = slope_q[SLOPE_W-1];
  assign next_level = {1'b0, p1_q.level, 15'b0};

  always_comb begin
    seg_d     = seg_q;
    slope_eff = slope_q;
    if (rel_q) begin
      seg_d = SUSTAIN;
    end else if (seg_q >= SUSTAIN) begin
      seg_d     = SUSTAIN;
      slope_eff = '0;
    end else if ((slope_pos && smooth_q > next_level) ||
                 (slope_neg && smooth_q < next_level)) begin
      seg_d = seg_q + AW'(1);
    end
  end

  assign raw_sum = $signed({{(SUM_W-ACC_W){1'b0}}, raw_q}) + SUM_W'(slope_eff);

  always_comb begin
    if (raw_sum[SUM_W-1]) begin
      raw_d = '0;
    end else if (raw_sum > $signed({{(SUM_W-ACC_W){1'b0}}, GAIN_MAX})) begin
      raw_d = GAIN_MAX;
    end else begin
      raw_d = raw_sum[ACC_W-1:0];
    end
  end

  // Q2.30 to Q1.15, rounded half up, saturated
  assign gain_sum = {1'b0, smooth_q} + (ACC_W+1)'(16384);
  assign gain     = (|gain_sum[ACC_W:ACC_W-1]) ? '1 : gain_sum[ACC_W-2 -: GAIN_W];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENV_SAMPLES);
  assign prdata = (paddr[2] == REG_ENV_SAMPLES) ? PDATA_W'(env_q) : '0;

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q    <= ENV_RESET;
      seg_q    <= '0;
      rel_q    <= 1'b1;
      raw_q    <= '0;
      smooth_q <= '0;
    end else begin
      if (cfg_wr) begin
        env_q <= pwdata[ENV_W-1:0];
      end
      if (accept) begin
        case (in_op)
          OP_START: begin
            rel_q <= 1'b0;
            seg_q <= '0;
            raw_q <= '0;
          end
          OP_RELEASE: begin
            rel_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (state_q == ST_UPD) begin
        seg_q <= seg_d;
        raw_q <= raw_d;
      end
      if (state_q == ST_MSM) begin
        smooth_q <= mix_sum[MIX_SUM_W-1:MIX_FRAC];
      end
    end
  end

  // tick working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_RD0: p0_q <= pt_rdata;
      ST_RD1: p1_q <= pt_rdata;
      ST_MULD: begin
        den_q <= mul_p[DIV_DEN_W-1:0];
        mag_q <= dl_mag;
        neg_q <= dl[LEVEL_W] ^ dt[TIME_W];
      end
      ST_DIVW: begin
        if (den_q == '0) begin
          slope_q <= '0;
        end else if (neg_q) begin
          slope_q <= -$signed({1'b0, div_quo});
        end else begin
          slope_q <= $signed({1'b0, div_quo});
        end
      end
      ST_MRAW: acc_q <= MIX_SUM_W'(mul_p) + MIX_HALF;
      default: begin
      end
    endcase
  end

  assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_axis_tready);

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_tdata_q  <= {(OUT_DATA_W-GAIN_W-SEG_W-1)'(0), rel_q, SEG_W'(seg_q), gain};
      end else if (m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (in_op == OP_TICK) ? ST_RD0 : ST_OUT;
          end
        end
        ST_RD0:  state_q <= ST_RD1;
        ST_RD1:  state_q <= ST_MULD;
        ST_MULD: state_q <= ST_DIVS;
        ST_DIVS: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD:  state_q <= ST_MRAW;
        ST_MRAW: state_q <= ST_MSM;
        ST_MSM:  state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  `BPE_ASSERT(a_raw_bounded, clk_i, rst_ni, raw_q <= GAIN_MAX)
  `BPE_ASSERT(a_smooth_bounded, clk_i, rst_ni, smooth_q <= GAIN_MAX)
  `BPE_ASSERT(a_seg_bounded, clk_i, rst_ni, seg_q <= SUSTAIN)

endmodule

// ===== src/bpe_points.sv =====
// Breakpoint table: one write port, one registered read port, valid bits for reset values.
`include "breakpoint_envelope_generator_macros.svh"

module bpe_points import bpe_pkg::*; #(
  parameter int BREAKPOINTS = BREAKPOINTS_DEF,
  localparam int AW = $clog2(BREAKPOINTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  point_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output point_t        rdata_o
);

  point_t                 mem_q [BREAKPOINTS];
  logic [BREAKPOINTS-1:0] valid_q;
  point_t                 rd_q;
  logic                   rd_valid_q;
  logic                   rd_last_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
      rd_last_q  <= (raddr_i == AW'(BREAKPOINTS - 1));
    end
  end

  // unwritten entries read as their reset value
  always_comb begin
    if (rd_valid_q) begin
      rdata_o = rd_q;
    end else begin
      rdata_o.level = '0;
      rdata_o.ptime = rd_last_q ? TIME_END : '0;
    end
  end

  `BPE_ASSERT_NEXT(a_write_sets_valid, clk_i, rst_ni, we_i, valid_q[$past(waddr_i)])

endmodule

// ===== src/bpe_div.sv =====
// Restoring divider, one quotient bit per cycle, for the segment slope.
`include "breakpoint_envelope_generator_macros.svh"

module bpe_div import bpe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [LEVEL_W-1:0]   num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] den_q;

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 take;

  assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign take   = !diff[DIV_DEN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= {num_i, {SLOPE_SHIFT{1'b0}}};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo_q <= {quo_q[DIV_NUM_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `BPE_ASSERT(a_rem_below_den, clk_i, rst_ni, (done_q && den_q != '0) |-> rem_q < den_q)

endmodule

// ===== dv/breakpoint_envelope_generator_tb.sv =====
// Self-checking testbench for the breakpoint envelope generator against an in-bench model.
module breakpoint_envelope_generator_tb import bpe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NPTS            = BREAKPOINTS_DEF;
  localparam int     SUSTAIN_SEG     = NPTS - 2;
  localparam longint RAW_CEIL        = 64'sd2147483648;
  localparam longint MIX_NEW         = 3277;
  localparam longint MIX_OLD         = 65536 - 3277;
  localparam int     CYCLE_LIMIT     = 1_000_000;
  localparam int     SETTLE_CYCLES   = 8;
  localparam int     TAIL_CYCLES     = 120;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     NPHASES         = 7;

  localparam logic [PADDR_W-1:0] ADDR_ENV_SAMPLES = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SPARE       = 3'd4;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [SEG_W-1:0]  segment;
    logic              releasing;
  } env_out_t;

  class envelope_tracker;
    bit [ENV_W-1:0]   env_samples;
    bit [TIME_W-1:0]  pt_time [NPTS];
    bit [LEVEL_W-1:0] pt_level [NPTS];
    int               seg;
    bit               released;
    longint           raw_q30;
    longint           smooth_q30;
    env_out_t         due_states[$];
    int unsigned      failures;

    function new();
      env_samples = ENV_RESET;
      foreach (pt_time[i]) begin
        pt_time[i]  = '0;
        pt_level[i] = '0;
      end
      pt_time[NPTS-1] = TIME_END;
      seg        = 0;
      released   = 1'b1;
      raw_q30    = 0;
      smooth_q30 = 0;
      failures   = 0;
    endfunction

    function void set_env(bit [ENV_W-1:0] v);
      env_samples = v;
    endfunction

    function longint slope_of(int s);
      longint dl, dt, den;
      if (s + 1 >= NPTS) return 0;
      dl  = longint'(pt_level[s+1]) - longint'(pt_level[s]);
      dt  = longint'(pt_time[s+1]) - longint'(pt_time[s]);
      den = longint'(env_samples) * dt;
      if (den == 0) return 0;
      return (dl * RAW_CEIL) / den;
    endfunction

    function void tick_step();
      longint slope, next_level;
      slope = slope_of(seg);
      if (released) begin
        seg = SUSTAIN_SEG;
      end else if (seg >= SUSTAIN_SEG) begin
        seg   = SUSTAIN_SEG;
        slope = 0;
      end else begin
        next_level = longint'(pt_level[seg+1]) * 32768;
        if ((slope > 0 && smooth_q30 > next_level) || (slope < 0 && smooth_q30 < next_level))
          seg++;
      end
      raw_q30 += slope;
      if (raw_q30 < 0) raw_q30 = 0;
      if (raw_q30 > RAW_CEIL) raw_q30 = RAW_CEIL;
      smooth_q30 = (smooth_q30 * MIX_OLD + raw_q30 * MIX_NEW + 32768) / 65536;
    endfunction

    function void apply_op(op_e op, bit [IDX_W-1:0] idx, bit [TIME_W-1:0] ptime,
                           bit [LEVEL_W-1:0] level);
      env_out_t o;
      longint   g;
      case (op)
        OP_TICK: tick_step();
        OP_START: begin
          released = 1'b0;
          seg      = 0;
          raw_q30  = 0;
        end
        OP_RELEASE: released = 1'b1;
        default: begin
          pt_time[idx]  = ptime;
          pt_level[idx] = level;
        end
      endcase
      g = (smooth_q30 + 16384) >>> 15;
      if (g > 65535) g = 65535;
      o.gain      = g[GAIN_W-1:0];
      o.segment   = seg[SEG_W-1:0];
      o.releasing = released;
      due_states.push_back(o);
    endfunction

    function int pending();
      return due_states.size();
    endfunction

    function void compare_output(logic [OUT_DATA_W-1:0] data);
      env_out_t want;
      if (due_states.size() == 0) begin
        $error("output beat with no pending state: data 0x%06h", data);
        failures++;
        return;
      end
      want = due_states.pop_front();
      if (data[GAIN_W-1:0] !== want.gain) begin
        $error("gain: expected %0d, actual %0d", want.gain, data[GAIN_W-1:0]);
        failures++;
      end
      if (data[GAIN_W +: SEG_W] !== want.segment) begin
        $error("segment: expected %0d, actual %0d", want.segment, data[GAIN_W +: SEG_W]);
        failures++;
      end
      if (data[GAIN_W+SEG_W] !== want.releasing) begin
        $error("releasing: expected %0d, actual %0d", want.releasing, data[GAIN_W+SEG_W]);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  envelope_tracker board = new();
  int unsigned     cycle_count = 0;
  int unsigned     beats_sent = 0;
  int unsigned     burst_left = 0;
  bit              hold_off_req = 1'b0;
  int unsigned     phase_env [NPHASES];
  int unsigned     phase_beats [NPHASES];

  breakpoint_envelope_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.compare_output(m_axis_tdata);
  end

  // receiver: random stall modes, plus a long hold-off on request
  initial begin
    int unsigned mode_left, mode, stall_left;
    bit          ready_next;
    mode_left     = 0;
    mode          = 0;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       ready_next = 1'b1;
          1:       ready_next = $urandom_range(0, 1);
          default: ready_next = ($urandom_range(0, 4) == 0);
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  task automatic hold_valid_low(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic send_item(op_e op, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] ptime,
                           logic [LEVEL_W-1:0] level);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) hold_valid_low(gap);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tdata  <= {4'b0, level, ptime, idx};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.apply_op(op, idx, ptime, level);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, IDX_W'($urandom_range(0, 7)), TIME_W'($urandom_range(0, 65536)),
              LEVEL_W'($urandom_range(0, 32768)));
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 19) == 0)
      send_item(op_e'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 7)),
                TIME_W'($urandom_range(0, 65536)), LEVEL_W'($urandom_range(0, 32768)));
  endtask

  task automatic tick_run(int unsigned n);
    repeat (n) begin
      maybe_noise();
      send_tick();
    end
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only while the block is idle
  task automatic set_env_samples(logic [ENV_W-1:0] v);
    logic [PDATA_W-1:0] rd;
    hold_valid_low(1);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    reg_write(ADDR_ENV_SAMPLES, {{(PDATA_W-ENV_W){1'b0}}, v});
    board.set_env(v);
    reg_write(ADDR_SPARE, $urandom());
    reg_read(ADDR_ENV_SAMPLES, rd);
    if (rd !== {{(PDATA_W-ENV_W){1'b0}}, v}) begin
      $error("envelope_samples: expected %0d, actual %0d", v, rd);
      board.failures++;
    end
  endtask

  task automatic run_envelope();
    int unsigned t_q[$];
    int unsigned tm [NPTS];
    int unsigned lv [NPTS];
    int unsigned shape, k, tmp;
    if ($urandom_range(0, 9) < 7) begin
      repeat (NPTS - 2) t_q.push_back($urandom_range(0, 65536));
      t_q.sort();
      tm[0] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, t_q[0]) : 0;
      for (int i = 1; i < NPTS - 1; i++) tm[i] = t_q[i-1];
      tm[NPTS-1] = ($urandom_range(0, 7) == 0) ? $urandom_range(tm[NPTS-2], 65536) : 65536;
      shape = $urandom_range(0, 9);
      k = $urandom_range(1, NPTS - 3);
      if (shape == 0) begin
        // out-of-order times
        tmp     = tm[k];
        tm[k]   = tm[k+1] + 1;
        tm[k+1] = tmp;
      end else if (shape == 1) begin
        tm[k+1] = tm[k];
      end
      foreach (lv[i]) begin
        case ($urandom_range(0, 5))
          0:       lv[i] = 0;
          1:       lv[i] = 32768;
          default: lv[i] = $urandom_range(0, 32768);
        endcase
      end
      for (int i = 0; i < NPTS; i++) begin
        maybe_noise();
        send_item(OP_WRITE, IDX_W'(i), TIME_W'(tm[i]), LEVEL_W'(lv[i]));
      end
    end
    send_item(OP_START, IDX_W'($urandom_range(0, 7)), TIME_W'($urandom_range(0, 65536)),
              LEVEL_W'($urandom_range(0, 32768)));
    tick_run($urandom_range(8, 90));
    send_item(OP_RELEASE, IDX_W'($urandom_range(0, 7)), TIME_W'($urandom_range(0, 65536)),
              LEVEL_W'($urandom_range(0, 32768)));
    tick_run($urandom_range(5, 50));
  endtask

  initial begin
    int unsigned target;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = ADDR_ENV_SAMPLES;
    pwdata        = '0;
    phase_env   = '{60, 1, 1048575, 0, 0, 0, ENV_RESET};
    phase_env[4] = $urandom_range(20, 200);
    phase_env[5] = $urandom_range(200, 3000);
    phase_beats = '{400, 250, 150, 100, 400, 300, 300};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, field extremes, zero-length and out-of-order segments
    send_item(OP_TICK, 3'd7, 17'd65536, 16'd32768);
    send_item(OP_RELEASE, 3'd0, 17'd0, 16'd0);
    send_item(OP_START, 3'd0, 17'd0, 16'd0);
    send_item(OP_TICK, 3'd0, 17'd0, 16'd0);
    send_item(OP_WRITE, 3'd0, 17'd0, 16'd0);
    send_item(OP_WRITE, 3'd7, 17'd65536, 16'd32768);
    send_item(OP_WRITE, 3'd6, 17'd65535, 16'd32767);
    send_item(OP_WRITE, 3'd1, 17'd0, 16'd32768);
    send_item(OP_WRITE, 3'd2, 17'd30000, 16'd16384);
    send_item(OP_WRITE, 3'd3, 17'd20000, 16'd32768);
    send_item(OP_WRITE, 3'd4, 17'd40000, 16'd0);
    send_item(OP_WRITE, 3'd5, 17'd50000, 16'd8000);
    send_item(OP_START, 3'd0, 17'd0, 16'd0);
    repeat (6) send_tick();
    send_item(OP_RELEASE, 3'd0, 17'd0, 16'd0);
    repeat (2) send_tick();
    send_item(OP_START, 3'd0, 17'd0, 16'd0);
    send_tick();

    hold_off_req = 1'b1;
    target = beats_sent;
    for (int p = 0; p < NPHASES; p++) begin
      set_env_samples(ENV_W'(phase_env[p]));
      if (p == 4) hold_off_req = 1'b1;
      target += phase_beats[p];
      while (beats_sent < target) run_envelope();
    end

    hold_valid_low(1);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== breakpoint_envelope_generator.f =====
+incdir+src
src/bpe_pkg.sv
src/bpe_points.sv
src/bpe_div.sv
src/breakpoint_envelope_generator.sv
dv/breakpoint_envelope_generator_tb.sv
